### design/isbct_pkg.sv
package isbct_pkg;

	localparam int WORD_BITS      = 32;
	localparam int NUM_WORDS      = 7;
	localparam int INDEX_BITS     = 6;
	localparam int OUT_STAMP_BITS = 48;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_FIND = 2'd1,
		OP_POP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_EMPTY    = 2'd1,
		STATUS_OVERFLOW = 2'd2,
		STATUS_NOTHING  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ADDR_LO,
		ADDR_LO1,
		ADDR_MID,
		ADDR_K
	} addr_sel_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_SIMPLE,
		OUT_FIND,
		OUT_POP
	} out_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_BISECT,
		ST_PAIR_A,
		ST_PAIR_B,
		ST_RESOLVE,
		ST_EMIT_SIMPLE,
		ST_FIND_EMIT,
		ST_POP_EMIT,
		ST_POP_READ
	} state_t;

	typedef struct packed {
		logic      accept;
		addr_sel_t addr_sel;
		logic      bis_step;
		logic      pair_save;
		logic      pair_decide;
		logic      set_nothing;
		out_kind_t out_kind;
	} ctl_t;

	typedef struct packed {
		logic count_zero;
		logic span_le1;
		logic span_eq2;
		logic lo_zero;
		logic find_op;
		logic out_free;
		logic k_last;
	} sts_t;

endpackage

### design/isbct_ctrl.sv
module isbct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         op,
	input  isbct_pkg::sts_t    sts,
	output logic               in_stall,
	output isbct_pkg::ctl_t    ctl
);

	isbct_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isbct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != isbct_pkg::ST_IDLE);

	always_comb begin
		state_d         = state_q;
		ctl.accept      = 1'b0;
		ctl.addr_sel    = isbct_pkg::ADDR_LO;
		ctl.bis_step    = 1'b0;
		ctl.pair_save   = 1'b0;
		ctl.pair_decide = 1'b0;
		ctl.set_nothing = 1'b0;
		ctl.out_kind    = isbct_pkg::OUT_NONE;
		case (state_q)
			isbct_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					case (op)
						isbct_pkg::OP_ADD: begin
							state_d = isbct_pkg::ST_EMIT_SIMPLE;
						end
						isbct_pkg::OP_FIND, isbct_pkg::OP_POP: begin
							state_d = sts.count_zero ? isbct_pkg::ST_EMIT_SIMPLE
							                         : isbct_pkg::ST_SEARCH;
						end
						default: begin
							state_d = isbct_pkg::ST_IDLE;
						end
					endcase
				end
			end
			isbct_pkg::ST_SEARCH: begin
				if (sts.span_le1) begin
					state_d = isbct_pkg::ST_RESOLVE;
				end else if (sts.span_eq2) begin
					ctl.addr_sel = isbct_pkg::ADDR_LO;
					state_d      = isbct_pkg::ST_PAIR_A;
				end else begin
					ctl.addr_sel = isbct_pkg::ADDR_MID;
					state_d      = isbct_pkg::ST_BISECT;
				end
			end
			isbct_pkg::ST_BISECT: begin
				ctl.addr_sel = isbct_pkg::ADDR_MID;
				ctl.bis_step = 1'b1;
				state_d      = isbct_pkg::ST_SEARCH;
			end
			isbct_pkg::ST_PAIR_A: begin
				ctl.pair_save = 1'b1;
				ctl.addr_sel  = isbct_pkg::ADDR_LO1;
				state_d       = isbct_pkg::ST_PAIR_B;
			end
			isbct_pkg::ST_PAIR_B: begin
				ctl.pair_decide = 1'b1;
				state_d         = isbct_pkg::ST_RESOLVE;
			end
			isbct_pkg::ST_RESOLVE: begin
				if (sts.find_op) begin
					ctl.addr_sel = isbct_pkg::ADDR_LO;
					state_d      = isbct_pkg::ST_FIND_EMIT;
				end else if (sts.lo_zero) begin
					ctl.set_nothing = 1'b1;
					state_d         = isbct_pkg::ST_EMIT_SIMPLE;
				end else begin
					ctl.addr_sel = isbct_pkg::ADDR_K;
					state_d      = isbct_pkg::ST_POP_EMIT;
				end
			end
			isbct_pkg::ST_EMIT_SIMPLE: begin
				if (sts.out_free) begin
					ctl.out_kind = isbct_pkg::OUT_SIMPLE;
					state_d      = isbct_pkg::ST_IDLE;
				end
			end
			isbct_pkg::ST_FIND_EMIT: begin
				ctl.addr_sel = isbct_pkg::ADDR_LO;
				if (sts.out_free) begin
					ctl.out_kind = isbct_pkg::OUT_FIND;
					state_d      = isbct_pkg::ST_IDLE;
				end
			end
			isbct_pkg::ST_POP_EMIT: begin
				ctl.addr_sel = isbct_pkg::ADDR_K;
				if (sts.out_free) begin
					ctl.out_kind = isbct_pkg::OUT_POP;
					state_d      = sts.k_last ? isbct_pkg::ST_IDLE : isbct_pkg::ST_POP_READ;
				end
			end
			isbct_pkg::ST_POP_READ: begin
				ctl.addr_sel = isbct_pkg::ADDR_K;
				state_d      = isbct_pkg::ST_POP_EMIT;
			end
			default: begin
				state_d = isbct_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### design/isbct_datapath.sv
module isbct_datapath #(
	parameter int DEPTH      = 64,
	parameter int STAMP_BITS = 48
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  isbct_pkg::ctl_t                          ctl,
	input  logic [1:0]                               op,
	input  logic [STAMP_BITS-1:0]                    stamp,
	input  logic [isbct_pkg::WORD_BITS-1:0]          acc_x,
	input  logic [isbct_pkg::WORD_BITS-1:0]          acc_y,
	input  logic [isbct_pkg::WORD_BITS-1:0]          acc_z,
	input  logic [isbct_pkg::WORD_BITS-1:0]          rate_x,
	input  logic [isbct_pkg::WORD_BITS-1:0]          rate_y,
	input  logic [isbct_pkg::WORD_BITS-1:0]          rate_z,
	input  logic [isbct_pkg::WORD_BITS-1:0]          step_time,
	input  logic                                     out_stall,
	output isbct_pkg::sts_t                          sts,
	output logic                                     out_valid,
	output logic [isbct_pkg::INDEX_BITS-1:0]         index,
	output logic [isbct_pkg::OUT_STAMP_BITS-1:0]     out_stamp,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_acc_x,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_acc_y,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_acc_z,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_rate_x,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_rate_y,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_rate_z,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_step_time,
	output logic                                     newer_available,
	output logic [1:0]                               status,
	output logic                                     last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int WB = isbct_pkg::WORD_BITS;
	localparam int EW = STAMP_BITS + isbct_pkg::NUM_WORDS * WB;
	localparam int IW = isbct_pkg::INDEX_BITS;

	// wrap a logical position onto a physical slot
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
	                                          input logic [CW-1:0] logical);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(logical);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [EW-1:0]         mem [DEPTH];
	logic [EW-1:0]         rd_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         head_q;
	logic [STAMP_BITS-1:0] newest_q;
	logic                  out_valid_q;

	logic [STAMP_BITS-1:0] t_q;
	logic [STAMP_BITS-1:0] dist_q;
	logic [CW-1:0]         lo_q, hi_q, k_q;
	logic                  find_q;
	logic                  newer_q;
	logic [IW-1:0]         idx_q;
	logic [1:0]            st_q;

	logic [IW-1:0]         index_q;
	logic [EW-1:0]         data_q;
	logic                  out_newer_q;
	logic [1:0]            status_q;
	logic                  last_q;

	logic [CW-1:0]         span, mid, mid1, hi_bis, lo1, rd_logical;
	logic [CW:0]           mid_sum;
	logic [AW-1:0]         rd_slot, wr_slot;
	logic [STAMP_BITS-1:0] rd_stamp, rd_dist;
	logic                  full, is_add, do_write, k_last, out_free, pop_done;

	always_comb begin
		span     = hi_q - lo_q;
		mid_sum  = (CW+1)'(lo_q) + (CW+1)'(hi_q);
		mid      = mid_sum[CW:1];
		mid1     = mid + CW'(1);
		hi_bis   = (mid1 < hi_q) ? mid1 : hi_q;
		lo1      = lo_q + CW'(1);
		case (ctl.addr_sel)
			isbct_pkg::ADDR_LO:  rd_logical = lo_q;
			isbct_pkg::ADDR_LO1: rd_logical = lo1;
			isbct_pkg::ADDR_MID: rd_logical = mid;
			isbct_pkg::ADDR_K:   rd_logical = k_q;
			default:             rd_logical = lo_q;
		endcase
		rd_slot  = slot_of(head_q, rd_logical);
		wr_slot  = slot_of(head_q, count_q);
		rd_stamp = rd_q[STAMP_BITS-1:0];
		rd_dist  = (rd_stamp >= t_q) ? (rd_stamp - t_q) : (t_q - rd_stamp);
		full     = (count_q == CW'(DEPTH));
		is_add   = (op == isbct_pkg::OP_ADD);
		do_write = ctl.accept && is_add && !full;
		k_last   = (k_q == lo_q);
		out_free = !out_valid_q || !out_stall;
		pop_done = (ctl.out_kind == isbct_pkg::OUT_POP) && k_last;
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.span_le1   = (span <= CW'(1));
	assign sts.span_eq2   = (span == CW'(2));
	assign sts.lo_zero    = (lo_q == '0);
	assign sts.find_op    = find_q;
	assign sts.out_free   = out_free;
	assign sts.k_last     = k_last;

	// sample store, read data registered
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_slot] <= {step_time, rate_z, rate_y, rate_x, acc_z, acc_y, acc_x, stamp};
		end
		rd_q <= mem[rd_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_q      <= '0;
			newest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_write) begin
				count_q  <= count_q + CW'(1);
				newest_q <= stamp;
			end
			if (pop_done) begin
				head_q  <= slot_of(head_q, lo1);
				count_q <= count_q - lo1;
			end
			if (ctl.out_kind != isbct_pkg::OUT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			t_q     <= stamp;
			find_q  <= (op == isbct_pkg::OP_FIND);
			lo_q    <= '0;
			hi_q    <= count_q;
			k_q     <= '0;
			newer_q <= is_add ? 1'b0 : (newest_q > stamp);
			if (is_add) begin
				idx_q <= full ? '0 : IW'(count_q);
				st_q  <= full ? isbct_pkg::STATUS_OVERFLOW : isbct_pkg::STATUS_OK;
			end else begin
				idx_q <= '0;
				st_q  <= isbct_pkg::STATUS_EMPTY;
			end
		end
		if (ctl.bis_step) begin
			if (rd_stamp > t_q) begin
				hi_q <= hi_bis;
			end else begin
				lo_q <= mid;
			end
		end
		if (ctl.pair_save) begin
			dist_q <= rd_dist;
		end
		if (ctl.pair_decide && (rd_dist < dist_q)) begin
			lo_q <= lo1;
		end
		if (ctl.set_nothing) begin
			idx_q <= '0;
			st_q  <= isbct_pkg::STATUS_NOTHING;
		end
		case (ctl.out_kind)
			isbct_pkg::OUT_SIMPLE: begin
				index_q     <= idx_q;
				data_q      <= '0;
				status_q    <= st_q;
				last_q      <= 1'b1;
				out_newer_q <= newer_q;
			end
			isbct_pkg::OUT_FIND: begin
				index_q     <= IW'(lo_q);
				data_q      <= rd_q;
				status_q    <= isbct_pkg::STATUS_OK;
				last_q      <= 1'b1;
				out_newer_q <= newer_q;
			end
			isbct_pkg::OUT_POP: begin
				index_q     <= IW'(k_q);
				data_q      <= rd_q;
				status_q    <= isbct_pkg::STATUS_OK;
				last_q      <= k_last;
				out_newer_q <= newer_q;
				k_q         <= k_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign index           = index_q;
	assign out_stamp       = isbct_pkg::OUT_STAMP_BITS'(data_q[STAMP_BITS-1:0]);
	assign out_acc_x       = data_q[STAMP_BITS + 0*WB +: WB];
	assign out_acc_y       = data_q[STAMP_BITS + 1*WB +: WB];
	assign out_acc_z       = data_q[STAMP_BITS + 2*WB +: WB];
	assign out_rate_x      = data_q[STAMP_BITS + 3*WB +: WB];
	assign out_rate_y      = data_q[STAMP_BITS + 4*WB +: WB];
	assign out_rate_z      = data_q[STAMP_BITS + 5*WB +: WB];
	assign out_step_time   = data_q[STAMP_BITS + 6*WB +: WB];
	assign newer_available = out_newer_q;
	assign status          = status_q;
	assign last            = last_q;

endmodule

### design/imu_sample_buffer_closest_time.sv
// Add: an emit state loads the result register once the output register is free;
// one item in flight. Find: each bisection step is a search and a bisect state with
// one store read each, paced by the single read port of the sample store.
// Pop: the search as for find, then per emitted entry a store read, then an output load.
// Reset: arst_n clears the count, head, newest time, FSM and output valid; the store
// itself is not cleared and needs no clearing pass.
module imu_sample_buffer_closest_time #(
	parameter int DEPTH      = 64,
	parameter int STAMP_BITS = 48
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [1:0]                               op,
	input  logic [STAMP_BITS-1:0]                    stamp,
	input  logic [isbct_pkg::WORD_BITS-1:0]          acc_x,
	input  logic [isbct_pkg::WORD_BITS-1:0]          acc_y,
	input  logic [isbct_pkg::WORD_BITS-1:0]          acc_z,
	input  logic [isbct_pkg::WORD_BITS-1:0]          rate_x,
	input  logic [isbct_pkg::WORD_BITS-1:0]          rate_y,
	input  logic [isbct_pkg::WORD_BITS-1:0]          rate_z,
	input  logic [isbct_pkg::WORD_BITS-1:0]          step_time,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [isbct_pkg::INDEX_BITS-1:0]         index,
	output logic [isbct_pkg::OUT_STAMP_BITS-1:0]     out_stamp,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_acc_x,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_acc_y,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_acc_z,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_rate_x,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_rate_y,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_rate_z,
	output logic [isbct_pkg::WORD_BITS-1:0]          out_step_time,
	output logic                                     newer_available,
	output logic [1:0]                               status,
	output logic                                     last
);

	// The controller sequences each transaction: accept in idle, step the bisection
	// (one store read per step, pair compare when two candidates remain), then load
	// the output register once per result. The datapath holds the ring store, the
	// head/count pointers, the search bounds and the output register.
	isbct_pkg::ctl_t ctl;
	isbct_pkg::sts_t sts;

	isbct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.sts      (sts),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	isbct_datapath #(
		.DEPTH      (DEPTH),
		.STAMP_BITS (STAMP_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.op              (op),
		.stamp           (stamp),
		.acc_x           (acc_x),
		.acc_y           (acc_y),
		.acc_z           (acc_z),
		.rate_x          (rate_x),
		.rate_y          (rate_y),
		.rate_z          (rate_z),
		.step_time       (step_time),
		.out_stall       (out_stall),
		.sts             (sts),
		.out_valid       (out_valid),
		.index           (index),
		.out_stamp       (out_stamp),
		.out_acc_x       (out_acc_x),
		.out_acc_y       (out_acc_y),
		.out_acc_z       (out_acc_z),
		.out_rate_x      (out_rate_x),
		.out_rate_y      (out_rate_y),
		.out_rate_z      (out_rate_z),
		.out_step_time   (out_step_time),
		.newer_available (newer_available),
		.status          (status),
		.last            (last)
	);

`ifndef SYNTHESIS
	// a recognised op must hold off the next transaction until its work is under way
	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (op == isbct_pkg::OP_ADD || op == isbct_pkg::OP_FIND ||
		op == isbct_pkg::OP_POP)) |=> in_stall)
		else $error("block idle right after accepting an op");

	// every non-ok result is the only result of its transaction
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != isbct_pkg::STATUS_OK) |-> last)
		else $error("error status on a non-final result");

	// while a pop still has entries to emit, no new input is taken
	a_pop_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> in_stall)
		else $error("input accepted in the middle of a pop");
`endif

endmodule

### sim/tb_top.sv
module tb_top;

	localparam int DEPTH        = 64;
	localparam int STAMP_W      = 48;
	localparam int RANDOM_ITEMS = 260;
	// Generous cap: a few hundred items, each with up to 64 results, every one of them
	// held by the longest stall the sink draws, stay well under a quarter of this.
	localparam int LIMIT        = 4000000;
	// Cycles to keep watching once nothing is awaited.
	localparam int SETTLE       = 40;

	// The one op code without a package name: the block must drop it silently.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	typedef logic [isbct_pkg::NUM_WORDS-1:0][isbct_pkg::WORD_BITS-1:0] word_vec_t;

	// One stored sample: time plus the seven opaque words (acc x/y/z, rate x/y/z, step).
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		word_vec_t          words;
	} entry_t;

	// One input transaction as queued for the driver.
	typedef struct {
		logic [1:0]         op;
		logic [STAMP_W-1:0] stamp;
		word_vec_t          words;
		int                 gap;
		bit                 drain;
	} cmd_t;

	// One result transaction as the buffer should present it.
	typedef struct {
		logic [isbct_pkg::INDEX_BITS-1:0]     idx;
		logic [isbct_pkg::OUT_STAMP_BITS-1:0] stamp;
		word_vec_t                            words;
		logic                                 newer;
		isbct_pkg::status_t                   status;
		logic                                 last;
	} result_t;

	// ---------------------------------------------------------------- clock, reset, ports
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #6 clk = ~clk;

	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic [1:0]                      op        = '0;
	logic [STAMP_W-1:0]              stamp     = '0;
	logic [isbct_pkg::WORD_BITS-1:0] acc_x     = '0;
	logic [isbct_pkg::WORD_BITS-1:0] acc_y     = '0;
	logic [isbct_pkg::WORD_BITS-1:0] acc_z     = '0;
	logic [isbct_pkg::WORD_BITS-1:0] rate_x    = '0;
	logic [isbct_pkg::WORD_BITS-1:0] rate_y    = '0;
	logic [isbct_pkg::WORD_BITS-1:0] rate_z    = '0;
	logic [isbct_pkg::WORD_BITS-1:0] step_time = '0;

	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [isbct_pkg::INDEX_BITS-1:0]     res_index;
	logic [isbct_pkg::OUT_STAMP_BITS-1:0] out_stamp;
	logic [isbct_pkg::WORD_BITS-1:0]      out_acc_x, out_acc_y, out_acc_z;
	logic [isbct_pkg::WORD_BITS-1:0]      out_rate_x, out_rate_y, out_rate_z;
	logic [isbct_pkg::WORD_BITS-1:0]      out_step_time;
	logic                                 newer_available;
	logic [1:0]                           status;
	logic                                 last;

	imu_sample_buffer_closest_time #(
		.DEPTH      (DEPTH),
		.STAMP_BITS (STAMP_W)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.stamp           (stamp),
		.acc_x           (acc_x),
		.acc_y           (acc_y),
		.acc_z           (acc_z),
		.rate_x          (rate_x),
		.rate_y          (rate_y),
		.rate_z          (rate_z),
		.step_time       (step_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.index           (res_index),
		.out_stamp       (out_stamp),
		.out_acc_x       (out_acc_x),
		.out_acc_y       (out_acc_y),
		.out_acc_z       (out_acc_z),
		.out_rate_x      (out_rate_x),
		.out_rate_y      (out_rate_y),
		.out_rate_z      (out_rate_z),
		.out_step_time   (out_step_time),
		.newer_available (newer_available),
		.status          (status),
		.last            (last)
	);

	// ---------------------------------------------------------------- shared bookkeeping
	cmd_t    cmd_queue[$];
	result_t awaited_results[$];
	int      total_cmds     = 0;
	int      accepted_count = 0;
	int      result_count   = 0;
	int      error_count    = 0;
	int      cycle_count    = 0;
	bit      in_taken       = 1'b0;

	string word_name[isbct_pkg::NUM_WORDS] = '{"acc_x", "acc_y", "acc_z", "rate_x", "rate_y",
		"rate_z", "step_time"};

	// ---------------------------------------------------------------- buffer mirror
	// Own copy of the ring: oldest entry at m_head, m_count entries live.
	entry_t             m_store[DEPTH];
	int                 m_head   = 0;
	int                 m_count  = 0;
	logic [STAMP_W-1:0] m_newest = '0;

	function automatic int ring_slot(input int logical);
		return (m_head + logical) % DEPTH;
	endfunction

	function automatic logic [STAMP_W-1:0] stamp_gap(input logic [STAMP_W-1:0] a,
		input logic [STAMP_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Bisection over logical indexes; on a tie in the final pair keep the lower index.
	function automatic int nearest_index(input logic [STAMP_W-1:0] t);
		int lo, hi, mid, found;
		bit done;
		lo = 0;
		hi = m_count;
		found = 0;
		done = 1'b0;
		while (!done) begin
			if (hi - lo <= 1) begin
				found = lo;
				done = 1'b1;
			end else if (hi - lo == 2) begin
				found = (stamp_gap(m_store[ring_slot(lo + 1)].stamp, t) <
					stamp_gap(m_store[ring_slot(lo)].stamp, t)) ? lo + 1 : lo;
				done = 1'b1;
			end else begin
				mid = (lo + hi) / 2;
				if (m_store[ring_slot(mid)].stamp > t)
					hi = (mid + 1 < hi) ? mid + 1 : hi;
				else
					lo = mid;
			end
		end
		return found;
	endfunction

	function automatic result_t make_result(input int idx, input entry_t e, input logic newer,
		input isbct_pkg::status_t st, input logic lst);
		result_t r;
		r.idx    = idx[isbct_pkg::INDEX_BITS-1:0];
		r.stamp  = e.stamp;
		r.words  = e.words;
		r.newer  = newer;
		r.status = st;
		r.last   = lst;
		return r;
	endfunction

	// Advance the mirror by one accepted transaction and queue what the buffer owes us.
	task automatic mirror_apply(input logic [1:0] op_v, input logic [STAMP_W-1:0] t,
		input word_vec_t w);
		int   hit;
		logic newer;
		newer = (m_newest > t);
		case (op_v)
			isbct_pkg::OP_ADD: begin
				if (m_count >= DEPTH) begin
					// full: drop the sample, keep the newest time
					awaited_results.push_back(make_result(0, '0, 1'b0,
						isbct_pkg::STATUS_OVERFLOW, 1'b1));
				end else begin
					m_store[ring_slot(m_count)] = '{stamp: t, words: w};
					m_newest = t;
					awaited_results.push_back(make_result(m_count, '0, 1'b0,
						isbct_pkg::STATUS_OK, 1'b1));
					m_count++;
				end
			end
			isbct_pkg::OP_FIND, isbct_pkg::OP_POP: begin
				if (m_count == 0) begin
					awaited_results.push_back(make_result(0, '0, newer,
						isbct_pkg::STATUS_EMPTY, 1'b1));
				end else begin
					hit = nearest_index(t);
					if (op_v == isbct_pkg::OP_FIND) begin
						awaited_results.push_back(make_result(hit, m_store[ring_slot(hit)], newer,
							isbct_pkg::STATUS_OK, 1'b1));
					end else if (hit == 0) begin
						awaited_results.push_back(make_result(0, '0, newer,
							isbct_pkg::STATUS_NOTHING, 1'b1));
					end else begin
						// emit entries 0..hit oldest first, then drop them from the ring
						for (int k = 0; k <= hit; k++)
							awaited_results.push_back(make_result(k, m_store[ring_slot(k)], newer,
								isbct_pkg::STATUS_OK, k == hit));
						m_head = ring_slot(hit + 1);
						m_count -= hit + 1;
					end
				end
			end
			default: begin
				// unused op: no result, no change
			end
		endcase
	endtask

	// ---------------------------------------------------------------- checking
	// Print one line per mismatch and count every one.
	task automatic report_mismatch(input string field, input logic [255:0] want,
		input logic [255:0] got);
		$display("result %0d: %s expected %0h, got %0h", result_count, field, want, got);
		error_count++;
	endtask

	// Sample everything at the rising edge: outputs first, then the input transaction.
	always @(posedge clk) begin : monitor_p
		result_t   want;
		word_vec_t got_words;
		cycle_count++;
		in_taken = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			got_words = {out_step_time, out_rate_z, out_rate_y, out_rate_x,
				out_acc_z, out_acc_y, out_acc_x};
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result, index", '0, res_index);
			end else begin
				want = awaited_results.pop_front();
				if (res_index !== want.idx)
					report_mismatch("index", want.idx, res_index);
				if (out_stamp !== want.stamp)
					report_mismatch("out_stamp", want.stamp, out_stamp);
				for (int j = 0; j < isbct_pkg::NUM_WORDS; j++)
					if (got_words[j] !== want.words[j])
						report_mismatch(word_name[j], want.words[j], got_words[j]);
				if (newer_available !== want.newer)
					report_mismatch("newer_available", want.newer, newer_available);
				if (status !== want.status)
					report_mismatch("status", want.status, status);
				if (last !== want.last)
					report_mismatch("last", want.last, last);
			end
			result_count++;
		end
		if (in_taken) begin
			accepted_count++;
			mirror_apply(op, stamp, {step_time, rate_z, rate_y, rate_x, acc_z, acc_y, acc_x});
		end
	end

	// ---------------------------------------------------------------- driver
	cmd_t cur_cmd;
	bit   holding_cmd = 1'b0;
	int   gap_left    = 0;

	// Drive at the falling edge. Hold a stalled transaction untouched; otherwise take the
	// next one, idle out its gap, and for a drain point wait until nothing is awaited.
	always @(negedge clk) begin : driver_p
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (!holding_cmd && cmd_queue.size() != 0) begin
				cur_cmd = cmd_queue.pop_front();
				holding_cmd = 1'b1;
				gap_left = cur_cmd.gap;
			end
			if (holding_cmd && cur_cmd.drain && awaited_results.size() != 0) begin
				in_valid <= 1'b0;
			end else if (holding_cmd && gap_left > 0) begin
				cur_cmd.drain = 1'b0;
				gap_left--;
				in_valid <= 1'b0;
			end else if (holding_cmd) begin
				op        <= cur_cmd.op;
				stamp     <= cur_cmd.stamp;
				acc_x     <= cur_cmd.words[0];
				acc_y     <= cur_cmd.words[1];
				acc_z     <= cur_cmd.words[2];
				rate_x    <= cur_cmd.words[3];
				rate_y    <= cur_cmd.words[4];
				rate_z    <= cur_cmd.words[5];
				step_time <= cur_cmd.words[6];
				in_valid  <= 1'b1;
				holding_cmd = 1'b0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- result back-pressure
	int stall_left = 0;
	int calm_left  = 0;

	// Mostly short stalls, a few long ones, and now and then a calm stretch with none.
	always @(negedge clk) begin : sink_p
		bit stall_next;
		int pick;
		stall_next = 1'b0;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					calm_left = $urandom_range(30, 200);
				else if (pick < 30)
					stall_left = $urandom_range(1, 3);
				else if (pick < 34)
					stall_left = $urandom_range(10, 30);
				if (stall_left > 0) begin
					stall_left--;
					stall_next = 1'b1;
				end
			end
			out_stall <= stall_next;
		end
	end

	// ---------------------------------------------------------------- stimulus building
	bit                 quiet_phase = 1'b0;
	logic [STAMP_W-1:0] gen_time    = '0;
	logic [STAMP_W-1:0] gen_step    = 48'd1;
	logic [STAMP_W-1:0] gen_recent[$];

	function automatic logic [STAMP_W-1:0] rand_stamp();
		return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
	endfunction

	// Random words with a fair share of all-zero and all-one patterns.
	function automatic word_vec_t rand_words();
		word_vec_t w;
		int pick;
		for (int j = 0; j < isbct_pkg::NUM_WORDS; j++) begin
			pick = $urandom_range(0, 9);
			w[j] = (pick == 0) ? '0 : (pick == 1) ? '1 : 32'($urandom);
		end
		return w;
	endfunction

	function automatic int pick_gap();
		int pick;
		if (quiet_phase)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic push_cmd(input logic [1:0] op_v, input logic [STAMP_W-1:0] t,
		input word_vec_t w, input bit drain);
		cmd_t c;
		c.op    = op_v;
		c.stamp = t;
		c.words = w;
		c.gap   = pick_gap();
		c.drain = drain;
		cmd_queue.push_back(c);
		total_cmds++;
	endtask

	// Append a sample one step after the last one and remember its time for queries.
	task automatic push_add(input bit drain);
		gen_time = gen_time + gen_step;
		push_cmd(isbct_pkg::OP_ADD, gen_time, rand_words(), drain);
		gen_recent.push_back(gen_time);
		if (gen_recent.size() > DEPTH)
			void'(gen_recent.pop_front());
	endtask

	// Query near a recent sample: on it, half way to the next (a tie for even steps),
	// either side of it, past the newest or before the oldest.
	function automatic logic [STAMP_W-1:0] make_query();
		logic [STAMP_W-1:0] s;
		int pick;
		if (gen_recent.size() == 0)
			return rand_stamp();
		s = gen_recent[$urandom_range(0, gen_recent.size() - 1)];
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2: return s;
			3, 4:    return s + (gen_step >> 1);
			5, 6:    return s + (rand_stamp() % (gen_step + 1));
			7:       return s - (rand_stamp() % (gen_step + 1));
			8:       return gen_time + gen_step;
			default: return gen_recent[0] - gen_step;
		endcase
	endfunction

	initial begin : stimulus_p
		int phase;
		int kind;
		int pick;
		int n_ops;

		// Directed part: empty buffer, unused op, extremes of time and words, a tie,
		// a pop whose nearest entry is the oldest, single-entry search and an empty pop
		// that still sees a later newest time.
		push_cmd(isbct_pkg::OP_FIND, '0, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_POP, STAMP_MAX, rand_words(), 1'b0);
		push_cmd(OP_UNUSED, STAMP_MAX, '1, 1'b0);
		push_cmd(isbct_pkg::OP_ADD, '0, '0, 1'b0);
		push_cmd(isbct_pkg::OP_ADD, 48'd100, '1, 1'b0);
		push_cmd(isbct_pkg::OP_ADD, 48'd200, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_FIND, 48'd150, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_FIND, '0, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_FIND, STAMP_MAX, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_POP, '0, rand_words(), 1'b1);
		push_cmd(isbct_pkg::OP_POP, 48'd100, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_FIND, '0, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_POP, 48'd300, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_ADD, STAMP_MAX, '1, 1'b0);
		push_cmd(isbct_pkg::OP_FIND, 48'd5, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_POP, STAMP_MAX, rand_words(), 1'b0);
		push_cmd(isbct_pkg::OP_POP, '0, '1, 1'b0);
		push_cmd(OP_UNUSED, '0, '0, 1'b0);

		// Random part in phases. The first phase always fills past capacity and starts
		// with a drain point; later phases pick fill, mixed traffic or noise.
		phase = 0;
		while (total_cmds < 18 + RANDOM_ITEMS) begin
			quiet_phase = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				gen_step = 48'd1;
			else if (pick == 1)
				gen_step = 48'($urandom);
			else if (pick < 7)
				gen_step = 48'(2 * $urandom_range(1, 500));
			else
				gen_step = 48'($urandom_range(1, 2000));
			if ($urandom_range(0, 4) == 0)
				gen_time = rand_stamp();
			kind = (phase == 0) ? 0 : $urandom_range(0, 9);
			if (kind < 2) begin
				// overrun the ring, look inside it, then pop most of it
				for (int k = 0; k < DEPTH + 2; k++)
					push_add(k == 0 && (phase == 0 || $urandom_range(0, 2) == 0));
				push_cmd(isbct_pkg::OP_FIND, make_query(), rand_words(), 1'b0);
				push_cmd(isbct_pkg::OP_POP, gen_time + gen_step, rand_words(), 1'b0);
			end else if (kind < 9) begin
				n_ops = $urandom_range(1, 12);
				for (int k = 0; k < n_ops; k++)
					push_add(k == 0 && $urandom_range(0, 2) == 0);
				n_ops = $urandom_range(2, 6);
				for (int k = 0; k < n_ops; k++) begin
					pick = $urandom_range(0, 9);
					if (pick < 4)
						push_cmd(isbct_pkg::OP_FIND, make_query(), rand_words(), 1'b0);
					else if (pick < 7)
						push_cmd(isbct_pkg::OP_POP, make_query(), rand_words(), 1'b0);
					else
						push_add(1'b0);
				end
			end else begin
				// noise: any op code, any time, any words
				for (int k = 0; k < 6; k++)
					push_cmd(2'($urandom_range(0, 3)), rand_stamp(), rand_words(), 1'b0);
			end
			phase++;
		end

		// Hold reset at the start, release it at a falling edge.
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for every transaction to be taken, then for every result, then settle.
		while (accepted_count < total_cmds && cycle_count < LIMIT)
			@(posedge clk);
		while (awaited_results.size() != 0 && cycle_count < LIMIT)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (cycle_count < LIMIT && error_count == 0 && awaited_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
